FILE: hw/rtl/aes_pkg.sv
// Package for the AES-128 encryption core: S-box table, GF(2^8) helpers, round functions.
// Used by aes_round_cell and aes128_block_encrypt_core; depends on nothing.
`default_nettype none
package aes_pkg;

    localparam int unsigned NumRounds   = 10;
    localparam int unsigned BlockBits   = 128;
    localparam int unsigned KeyRegIdxW  = 1;

    typedef enum logic [KeyRegIdxW-1:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } cfg_reg_t;

    typedef logic [BlockBits-1:0] block_t;

    // Data that moves from one round cell to the next.
    typedef struct packed {
        logic   valid;
        block_t state;
        block_t rkey;
        logic [7:0] rcon;
    } cell_bus_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits in bits [127-8i -: 8].
    function automatic logic [7:0] get_byte(input block_t b, input int unsigned i);
        return b[BlockBits-1-8*i -: 8];
    endfunction

    // SubBytes and ShiftRows together.
    function automatic block_t sub_shift(input block_t s);
        block_t t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[BlockBits-1-8*(4*c+r) -: 8] = SBOX[get_byte(s, 4*((c+r)%4)+r)];
            end
        end
        return t;
    endfunction

    function automatic block_t mix_columns(input block_t s);
        block_t t;
        logic [7:0] a [4];
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                a[r] = get_byte(s, 4*c+r);
            end
            for (int r = 0; r < 4; r++) begin
                t[BlockBits-1-8*(4*c+r) -: 8] = xtime(a[r]) ^ xtime(a[(r+1)%4])
                    ^ a[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
            end
        end
        return t;
    endfunction

    // Next round key from the previous one and its round constant.
    function automatic block_t next_key(input block_t k, input logic [7:0] rc);
        block_t n;
        logic [31:0] w;
        logic [31:0] tw;
        w  = k[31:0];
        tw = {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
        n[127:96] = k[127:96] ^ tw;
        n[95:64]  = k[95:64] ^ n[127:96];
        n[63:32]  = k[63:32] ^ n[95:64];
        n[31:0]   = k[31:0] ^ n[63:32];
        return n;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/aes_round_cell.sv
// One AES round cell: derives its round key and applies one round, registered.
// Depends on aes_pkg.
`default_nettype none
module aes_round_cell
    import aes_pkg::*;
#(
    parameter bit LastRound = 1'b0
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      advance,
    input  wire cell_bus_t prev,
    output cell_bus_t      next
);

    logic   valid_reg;
    block_t state_reg;
    block_t rkey_reg;
    logic [7:0] rcon_reg;
    block_t key_next;
    block_t state_next;
    block_t ss;

    always_comb
    begin
        key_next = next_key(prev.rkey, prev.rcon);
        ss       = sub_shift(prev.state);
        if (LastRound)
        begin
            state_next = ss ^ key_next;
        end
        else
        begin
            state_next = mix_columns(ss) ^ key_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            state_reg <= state_next;
            rkey_reg  <= key_next;
            rcon_reg  <= xtime(prev.rcon);
        end
    end

    assign next = '{valid: valid_reg, state: state_reg, rkey: rkey_reg, rcon: rcon_reg};

endmodule
`default_nettype wire

FILE: hw/rtl/aes128_block_encrypt_core.sv
// AES-128 core: a block reaches the output register through the input stage and then the round cells.
// Throughput: one block per cycle while the output is not stalled; ten round cells and an input stage form a pipeline.
// The whole chain advances together and stalls only when the output beat is not taken.
// Reset (rst_n, asynchronous, active low) clears all valid flags and both key registers.
// Each block carries its own copy of the key down the chain, so key writes affect only
// blocks accepted afterwards.
`default_nettype none
module aes128_block_encrypt_core
    import aes_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [63:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [127:0] s_axis_tdata,   // [63:0] plaintext_high, [127:64] plaintext_low
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [127:0]      m_axis_tdata    // [63:0] ciphertext_high, [127:64] ciphertext_low
);

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // The pipeline moves when the last stage is empty or its beat is being taken.
    logic advance;
    assign advance       = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // Input stage: initial AddRoundKey with the cipher key.
    cell_bus_t bus [NumRounds+1];
    logic   in_valid_reg;
    block_t in_state_reg;
    block_t in_key_reg;
    block_t cipher_key;
    block_t plain;

    assign cipher_key = {key_high_reg, key_low_reg};
    assign plain      = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            in_state_reg <= plain ^ cipher_key;
            in_key_reg   <= cipher_key;
        end
    end

    assign bus[0] = '{valid: in_valid_reg, state: in_state_reg, rkey: in_key_reg, rcon: 8'h01};

    for (genvar g = 0; g < NumRounds; g++)
    begin : g_round
        aes_round_cell #(
            .LastRound(g == NumRounds - 1)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .prev   (bus[g]),
            .next   (bus[g+1])
        );
    end

    assign m_axis_tvalid = bus[NumRounds].valid;
    assign m_axis_tdata  = {bus[NumRounds].state[63:0], bus[NumRounds].state[127:64]};

endmodule
`default_nettype wire

FILE: hw/rtl/aes128_block_encrypt_core_checker.sv
// Port-level checker for the AES-128 core, bound to the top level.
// Depends on aes128_block_encrypt_core.
`default_nettype none
module aes_core_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [127:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output beat changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");

    a_no_out_after_reset: assert property (@(posedge clk)
        !rst_n |=> !m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

bind aes128_block_encrypt_core aes_core_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
`default_nettype wire
